FILE: design/euclidean_distance_transform_defines.svh
// Assertion helpers used by the distance transform RTL.
`ifndef EUCLIDEAN_DISTANCE_TRANSFORM_DEFINES_SVH
`define EUCLIDEAN_DISTANCE_TRANSFORM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define EDT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define EDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/edt_pkg.sv
package edt_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int CFG_DIM_W   = 9;
    localparam int CFG_SCALE_W = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam int SQ_W = 20;
    localparam int MM_W = 24;

    localparam logic [SQ_W-1:0] SQ_MAX = 20'hFFFFF;

    localparam logic [CFG_DIM_W-1:0]   RST_IMAGE_WIDTH  = 9'd256;
    localparam logic [CFG_DIM_W-1:0]   RST_IMAGE_HEIGHT = 9'd256;
    localparam logic [CFG_SCALE_W-1:0] RST_MM_PER_PIXEL = 16'd4096;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MM_PER_PIXEL = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

endpackage

FILE: design/edt_ram.sv
module edt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/euclidean_distance_transform.sv
// Exact two-pass Euclidean distance transform of a binary image. Load items
// (op = 0) bring pixels in raster order; the load marked frame_end pads any
// missing pixels as background and starts the transform, during which o_ready
// stays low. The transform runs out of a column-distance memory, a
// squared-result memory and two envelope memories (one read port each,
// registered): padding writes each missing pixel, the column pass reads and
// writes back each pixel in each direction, the row pass pops hidden envelope
// parabolas and runs a bit-serial divider for each separator, and the
// back-fill writes each pixel's squared distance.
// Fetch items (op = 1) return the pixel's squared distance and its distance in
// Q16.8 mm; a fetch reads the memory, applies two scaling multiplies and runs
// a 26-step square root. A finished result waits in the output register while
// the next item is accepted.
`include "euclidean_distance_transform_defines.svh"

module euclidean_distance_transform #(
    parameter int MAX_WIDTH  = edt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = edt_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [edt_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [edt_pkg::CFG_DATA_W-1:0]   i_cfg_wr_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_op,
    input  logic                             i_pixel_set,
    input  logic                             i_frame_end,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [edt_pkg::MM_W-1:0]         o_distance_mm,
    output logic [edt_pkg::SQ_W-1:0]         o_distance_squared,
    output logic                             o_last_result
);

    localparam int MAXPIX = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(MAXPIX);
    localparam int PCW    = $clog2(MAXPIX + 1);
    localparam int IW     = $clog2(MAX_WIDTH);
    localparam int HIW    = $clog2(MAX_HEIGHT);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int CDW    = $clog2(MAX_WIDTH + 2 * MAX_HEIGHT);
    localparam int SUMW   = 2 * CDW + 1;
    localparam int D2W    = (SUMW > edt_pkg::SQ_W) ? SUMW : edt_pkg::SQ_W + 1;
    localparam int NUMW   = 2 * CDW + 2;
    localparam int MAGW   = NUMW - 1;
    localparam int PRW    = edt_pkg::SQ_W + edt_pkg::CFG_SCALE_W;
    localparam int ROOTW  = (edt_pkg::SQ_W + 2 * edt_pkg::CFG_SCALE_W + 1) / 2;
    localparam int RADW   = 2 * ROOTW;
    localparam int CNTMAX = (MAGW > ROOTW) ? MAGW : ROOTW;
    localparam int CNTW   = $clog2(CNTMAX + 1);

    typedef enum logic [19:0] {
        S_IDLE   = 20'h00001,
        S_FILL   = 20'h00002,
        S_C_RD   = 20'h00004,
        S_C_WR   = 20'h00008,
        S_R_INIT = 20'h00010,
        S_R_GU   = 20'h00020,
        S_R_GU2  = 20'h00040,
        S_R_ENV  = 20'h00080,
        S_R_GS   = 20'h00100,
        S_R_CMP  = 20'h00200,
        S_R_CMP2 = 20'h00400,
        S_R_DIV  = 20'h00800,
        S_R_SEP  = 20'h01000,
        S_B_ENV  = 20'h02000,
        S_B_GS   = 20'h04000,
        S_B_CALC = 20'h08000,
        S_F_MUL1 = 20'h10000,
        S_F_MUL2 = 20'h20000,
        S_F_SQRT = 20'h40000,
        S_F_DONE = 20'h80000
    } t_state;

    // Configuration registers.
    logic [edt_pkg::CFG_DIM_W-1:0]   r_image_width, r_image_height;
    logic [edt_pkg::CFG_SCALE_W-1:0] r_mm_per_pixel;

    // Control and datapath registers.
    t_state            r_state, n_state;
    logic [PCW-1:0]    r_lpos, n_lpos, r_fpos, n_fpos;
    logic [PCW-1:0]    r_p, n_p, r_base, n_base;
    logic [IW-1:0]     r_i, n_i, r_u, n_u, r_q, n_q, r_src, n_src, r_start, n_start;
    logic [HIW-1:0]    r_j, n_j;
    logic              r_up, n_up;
    logic [CDW-1:0]    r_prev, n_prev;
    logic [2*CDW-1:0]  r_gu2, n_gu2, r_gs2, n_gs2;
    logic [2*IW-1:0]   r_dx1s, n_dx1s, r_dx2s, n_dx2s;
    logic              r_neg, n_neg;
    logic [MAGW-1:0]   r_dq, n_dq;
    logic [IW:0]       r_rem, n_rem, r_den, n_den;
    logic [CNTW-1:0]   r_cnt, n_cnt;
    logic [edt_pkg::SQ_W-1:0] r_d2, n_d2;
    logic [PRW-1:0]    r_prod, n_prod;
    logic [RADW-1:0]   r_rad, n_rad;
    logic [ROOTW-1:0]  r_root, n_root;
    logic [ROOTW+1:0]  r_srem, n_srem;
    logic              r_flast, n_flast;
    logic              r_out_valid, n_out_valid;
    logic [edt_pkg::MM_W-1:0] r_out_mm, n_out_mm;
    logic [edt_pkg::SQ_W-1:0] r_out_sq, n_out_sq;
    logic              r_out_last, n_out_last;

    // Memory ports.
    logic              col_we;
    logic [PCW-1:0]    col_wa_f, col_ra_f;
    logic [CDW-1:0]    col_wd, col_rd;
    logic              env_src_we, env_start_we;
    logic [IW-1:0]     env_wa, env_src_wd, env_start_wd, env_src_rd, env_start_rd;
    logic              sq_we;
    logic [PCW-1:0]    sq_wa_f, sq_ra_f;
    logic [edt_pkg::SQ_W-1:0] sq_wd, sq_rd;

    // Frame geometry, clamped to the supported size.
    logic [WW-1:0]     w, w_m1;
    logic [HW-1:0]     h, h_m1;
    logic [CDW-1:0]    inf;
    logic [PCW-1:0]    n_pix, fetch_p;

    always_comb begin
        if (r_image_width == '0) begin
            w = WW'(1);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(r_image_width);
        end
        if (r_image_height == '0) begin
            h = HW'(1);
        end else if (32'(r_image_height) > MAX_HEIGHT) begin
            h = HW'(MAX_HEIGHT);
        end else begin
            h = HW'(r_image_height);
        end
    end

    assign w_m1    = w - 1'b1;
    assign h_m1    = h - 1'b1;
    assign inf     = CDW'(w) + CDW'(h);
    assign n_pix   = PCW'(w) * PCW'(h);
    // Fetch position wraps to the first pixel when it lies outside the current frame.
    assign fetch_p = (r_fpos >= n_pix) ? '0 : r_fpos;

    logic in_acc;
    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= edt_pkg::RST_IMAGE_WIDTH;
            r_image_height <= edt_pkg::RST_IMAGE_HEIGHT;
            r_mm_per_pixel <= edt_pkg::RST_MM_PER_PIXEL;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                edt_pkg::REG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_wr_data[edt_pkg::CFG_DIM_W-1:0];
                end
                edt_pkg::REG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_wr_data[edt_pkg::CFG_DIM_W-1:0];
                end
                edt_pkg::REG_MM_PER_PIXEL: begin
                    r_mm_per_pixel <= i_cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Helper terms used by the sequencer.
    logic              u_last, j_last, i_last;
    logic [IW-1:0]     dx1, dx2, dxb, diff;
    logic [IW:0]       sum_us;
    logic [SUMW-1:0]   par_a, par_b;
    logic [NUMW-1:0]   num;
    logic [IW+1:0]     div_t;
    logic              div_ge;
    logic              sep_ok, q_zero, q_one;
    logic [IW-1:0]     sep_st;
    logic [D2W-1:0]    d2_full;
    logic [ROOTW+3:0]  sq_t, sq_trial;
    logic              sq_ge;
    logic [ROOTW:0]    mm_rnd;

    assign u_last = (WW'(r_u) == w_m1);
    assign j_last = (HW'(r_j) == h_m1);
    assign i_last = (WW'(r_i) == w_m1);

    assign dx1    = (r_start >= r_src) ? r_start - r_src : r_src - r_start;
    assign dx2    = (r_start >= r_u) ? r_start - r_u : r_u - r_start;
    assign dxb    = (r_u >= r_src) ? r_u - r_src : r_src - r_u;
    assign diff   = r_u - r_src;
    assign sum_us = (IW+1)'(r_u) + (IW+1)'(r_src);
    assign par_a  = SUMW'(r_dx1s) + SUMW'(r_gs2);
    assign par_b  = SUMW'(r_dx2s) + SUMW'(r_gu2);
    assign num    = NUMW'(diff) * NUMW'(sum_us) + NUMW'(r_gu2) - NUMW'(r_gs2);

    assign div_t  = {r_rem, r_dq[MAGW-1]};
    assign div_ge = (div_t >= (IW+2)'(r_den));

    // Separator plus one, as unsigned, must land inside the row.
    assign q_zero = (r_dq == '0);
    assign q_one  = (r_dq == MAGW'(1));
    assign sep_ok = r_neg ? (q_zero || q_one)
                          : ((MAGW+1)'(r_dq) + 1'b1 < (MAGW+1)'(w));
    assign sep_st = r_neg ? (q_zero ? IW'(1) : '0) : IW'(r_dq + 1'b1);

    assign d2_full = D2W'(dxb) * D2W'(dxb) + D2W'(col_rd) * D2W'(col_rd);

    assign sq_t     = {r_srem, r_rad[RADW-1 -: 2]};
    assign sq_trial = (ROOTW+4)'({r_root, 2'b01});
    assign sq_ge    = (sq_t >= sq_trial);
    assign mm_rnd   = (ROOTW+1)'(r_root) + (ROOTW+1)'(8);

    always_comb begin
        n_state     = r_state;
        n_lpos      = r_lpos;
        n_fpos      = r_fpos;
        n_p         = r_p;
        n_base      = r_base;
        n_i         = r_i;
        n_u         = r_u;
        n_q         = r_q;
        n_src       = r_src;
        n_start     = r_start;
        n_j         = r_j;
        n_up        = r_up;
        n_prev      = r_prev;
        n_gu2       = r_gu2;
        n_gs2       = r_gs2;
        n_dx1s      = r_dx1s;
        n_dx2s      = r_dx2s;
        n_neg       = r_neg;
        n_dq        = r_dq;
        n_rem       = r_rem;
        n_den       = r_den;
        n_cnt       = r_cnt;
        n_d2        = r_d2;
        n_prod      = r_prod;
        n_rad       = r_rad;
        n_root      = r_root;
        n_srem      = r_srem;
        n_flast     = r_flast;
        n_out_valid = r_out_valid && !i_ready;
        n_out_mm    = r_out_mm;
        n_out_sq    = r_out_sq;
        n_out_last  = r_out_last;

        col_we       = 1'b0;
        col_wa_f     = r_p;
        col_wd       = inf;
        col_ra_f     = r_p;
        env_src_we   = 1'b0;
        env_start_we = 1'b0;
        env_wa       = '0;
        env_src_wd   = r_u;
        env_start_wd = '0;
        sq_we        = 1'b0;
        sq_wa_f      = r_base + PCW'(r_u);
        sq_wd        = (d2_full > D2W'(edt_pkg::SQ_MAX)) ? edt_pkg::SQ_MAX
                                                         : edt_pkg::SQ_W'(d2_full);
        sq_ra_f      = fetch_p;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_op == edt_pkg::OP_LOAD) begin
                    // Store the pixel; drop it past the end of the frame.
                    col_wa_f = r_lpos;
                    col_wd   = i_pixel_set ? '0 : inf;
                    col_we   = (r_lpos < n_pix);
                    if (i_frame_end) begin
                        n_lpos = '0;
                        n_fpos = '0;
                        if (r_lpos + 1'b1 < n_pix) begin
                            n_p     = r_lpos + 1'b1;
                            n_state = S_FILL;
                        end else begin
                            n_p     = '0;
                            n_i     = '0;
                            n_j     = '0;
                            n_up    = 1'b0;
                            n_state = S_C_RD;
                        end
                    end else if (r_lpos < n_pix) begin
                        n_lpos = r_lpos + 1'b1;
                    end
                end else if (in_acc) begin
                    n_flast = (fetch_p == n_pix - 1'b1);
                    n_fpos  = (fetch_p == n_pix - 1'b1) ? '0 : fetch_p + 1'b1;
                    n_state = S_F_MUL1;
                end
            end
            S_FILL: begin
                // Pad the rest of a short frame as background.
                col_we = 1'b1;
                if (r_p + 1'b1 < n_pix) begin
                    n_p = r_p + 1'b1;
                end else begin
                    n_p     = '0;
                    n_i     = '0;
                    n_j     = '0;
                    n_up    = 1'b0;
                    n_state = S_C_RD;
                end
            end
            S_C_RD: begin
                n_state = S_C_WR;
            end
            S_C_WR: begin
                if (!r_up) begin
                    col_we = (col_rd != '0);
                    col_wd = (r_j == '0) ? inf : r_prev + 1'b1;
                    n_prev = (col_rd == '0) ? '0 : col_wd;
                end else begin
                    col_we = (r_prev < col_rd);
                    col_wd = r_prev + 1'b1;
                    n_prev = (r_prev < col_rd) ? col_wd : col_rd;
                end
                n_state = S_C_RD;
                if (!r_up && !j_last) begin
                    n_j = r_j + 1'b1;
                    n_p = r_p + PCW'(w);
                end else if (!r_up && h != HW'(1)) begin
                    n_j  = HIW'(h - 2'd2);
                    n_p  = r_p - PCW'(w);
                    n_up = 1'b1;
                end else if (r_up && r_j != '0) begin
                    n_j = r_j - 1'b1;
                    n_p = r_p - PCW'(w);
                end else if (!i_last) begin
                    n_i  = r_i + 1'b1;
                    n_p  = PCW'(r_i) + 1'b1;
                    n_j  = '0;
                    n_up = 1'b0;
                end else begin
                    n_j     = '0;
                    n_base  = '0;
                    n_state = S_R_INIT;
                end
            end
            S_R_INIT: begin
                env_src_we   = 1'b1;
                env_start_we = 1'b1;
                env_wa       = '0;
                env_src_wd   = '0;
                env_start_wd = '0;
                n_q          = '0;
                if (w == WW'(1)) begin
                    n_u     = '0;
                    n_state = S_B_ENV;
                end else begin
                    n_u     = IW'(1);
                    n_state = S_R_GU;
                end
            end
            S_R_GU: begin
                col_ra_f = r_base + PCW'(r_u);
                n_state  = S_R_GU2;
            end
            S_R_GU2: begin
                n_gu2   = (2*CDW)'(col_rd) * (2*CDW)'(col_rd);
                n_state = S_R_ENV;
            end
            S_R_ENV: begin
                n_state = S_R_GS;
            end
            S_R_GS: begin
                n_src    = env_src_rd;
                n_start  = env_start_rd;
                col_ra_f = r_base + PCW'(env_src_rd);
                n_state  = S_R_CMP;
            end
            S_R_CMP: begin
                n_gs2   = (2*CDW)'(col_rd) * (2*CDW)'(col_rd);
                n_dx1s  = (2*IW)'(dx1) * (2*IW)'(dx1);
                n_dx2s  = (2*IW)'(dx2) * (2*IW)'(dx2);
                n_state = S_R_CMP2;
            end
            S_R_CMP2: begin
                if (par_a > par_b) begin
                    // Pop the hidden parabola; an empty envelope restarts at u.
                    if (r_q == '0) begin
                        env_src_we = 1'b1;
                        env_wa     = '0;
                        env_src_wd = r_u;
                        if (u_last) begin
                            n_state = S_B_ENV;
                        end else begin
                            n_u     = r_u + 1'b1;
                            n_state = S_R_GU;
                        end
                    end else begin
                        n_q     = r_q - 1'b1;
                        n_state = S_R_ENV;
                    end
                end else begin
                    n_neg   = num[NUMW-1];
                    n_dq    = num[NUMW-1] ? MAGW'(-num) : MAGW'(num);
                    n_rem   = '0;
                    n_den   = {diff, 1'b0};
                    n_cnt   = '0;
                    n_state = S_R_DIV;
                end
            end
            S_R_DIV: begin
                n_rem = (IW+1)'(div_ge ? div_t - (IW+2)'(r_den) : div_t);
                n_dq  = {r_dq[MAGW-2:0], div_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNTW'(MAGW - 1)) begin
                    n_state = S_R_SEP;
                end
            end
            S_R_SEP: begin
                if (sep_ok) begin
                    env_src_we   = 1'b1;
                    env_start_we = 1'b1;
                    env_wa       = r_q + 1'b1;
                    env_src_wd   = r_u;
                    env_start_wd = sep_st;
                    n_q          = r_q + 1'b1;
                end
                if (u_last) begin
                    n_state = S_B_ENV;
                end else begin
                    n_u     = r_u + 1'b1;
                    n_state = S_R_GU;
                end
            end
            S_B_ENV: begin
                n_state = S_B_GS;
            end
            S_B_GS: begin
                n_src    = env_src_rd;
                n_start  = env_start_rd;
                col_ra_f = r_base + PCW'(env_src_rd);
                n_state  = S_B_CALC;
            end
            S_B_CALC: begin
                sq_we = 1'b1;
                if (r_u == r_start && r_q != '0) begin
                    n_q = r_q - 1'b1;
                end
                if (r_u != '0) begin
                    n_u     = r_u - 1'b1;
                    n_state = S_B_ENV;
                end else if (!j_last) begin
                    n_j     = r_j + 1'b1;
                    n_base  = r_base + PCW'(w);
                    n_state = S_R_INIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_F_MUL1: begin
                n_d2    = sq_rd;
                n_prod  = PRW'(sq_rd) * PRW'(r_mm_per_pixel);
                n_state = S_F_MUL2;
            end
            S_F_MUL2: begin
                n_rad   = RADW'(r_prod) * RADW'(r_mm_per_pixel);
                n_root  = '0;
                n_srem  = '0;
                n_cnt   = '0;
                n_state = S_F_SQRT;
            end
            S_F_SQRT: begin
                // One root bit per step, two radicand bits consumed.
                n_srem = (ROOTW+2)'(sq_ge ? sq_t - sq_trial : sq_t);
                n_root = {r_root[ROOTW-2:0], sq_ge};
                n_rad  = {r_rad[RADW-3:0], 2'b00};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNTW'(ROOTW - 1)) begin
                    n_state = S_F_DONE;
                end
            end
            S_F_DONE: begin
                // Hold until the output register frees up.
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_mm    = edt_pkg::MM_W'(mm_rnd >> 4);
                    n_out_sq    = r_d2;
                    n_out_last  = r_flast;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lpos      <= '0;
            r_fpos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lpos      <= n_lpos;
            r_fpos      <= n_fpos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p        <= n_p;
        r_base     <= n_base;
        r_i        <= n_i;
        r_u        <= n_u;
        r_q        <= n_q;
        r_src      <= n_src;
        r_start    <= n_start;
        r_j        <= n_j;
        r_up       <= n_up;
        r_prev     <= n_prev;
        r_gu2      <= n_gu2;
        r_gs2      <= n_gs2;
        r_dx1s     <= n_dx1s;
        r_dx2s     <= n_dx2s;
        r_neg      <= n_neg;
        r_dq       <= n_dq;
        r_rem      <= n_rem;
        r_den      <= n_den;
        r_cnt      <= n_cnt;
        r_d2       <= n_d2;
        r_prod     <= n_prod;
        r_rad      <= n_rad;
        r_root     <= n_root;
        r_srem     <= n_srem;
        r_flast    <= n_flast;
        r_out_mm   <= n_out_mm;
        r_out_sq   <= n_out_sq;
        r_out_last <= n_out_last;
    end

    // Vertical distances, one entry per pixel.
    edt_ram #(.WIDTH(CDW), .DEPTH(MAXPIX)) u_col_ram (
        .i_clk     (i_clk),
        .i_wr_en   (col_we),
        .i_wr_addr (col_wa_f[AW-1:0]),
        .i_wr_data (col_wd),
        .i_rd_addr (col_ra_f[AW-1:0]),
        .o_rd_data (col_rd)
    );

    // Squared distances, one entry per pixel.
    edt_ram #(.WIDTH(edt_pkg::SQ_W), .DEPTH(MAXPIX)) u_sq_ram (
        .i_clk     (i_clk),
        .i_wr_en   (sq_we),
        .i_wr_addr (sq_wa_f[AW-1:0]),
        .i_wr_data (sq_wd),
        .i_rd_addr (sq_ra_f[AW-1:0]),
        .o_rd_data (sq_rd)
    );

    // Envelope parabola sources and starts, indexed by envelope slot.
    edt_ram #(.WIDTH(IW), .DEPTH(MAX_WIDTH)) u_env_src_ram (
        .i_clk     (i_clk),
        .i_wr_en   (env_src_we),
        .i_wr_addr (env_wa),
        .i_wr_data (env_src_wd),
        .i_rd_addr (r_q),
        .o_rd_data (env_src_rd)
    );

    edt_ram #(.WIDTH(IW), .DEPTH(MAX_WIDTH)) u_env_start_ram (
        .i_clk     (i_clk),
        .i_wr_en   (env_start_we),
        .i_wr_addr (env_wa),
        .i_wr_data (env_start_wd),
        .i_rd_addr (r_q),
        .o_rd_data (env_start_rd)
    );

    assign o_valid            = r_out_valid;
    assign o_distance_mm      = r_out_mm;
    assign o_distance_squared = r_out_sq;
    assign o_last_result      = r_out_last;

    `EDT_ASSERT_NEXT(a_fetch_starts, i_clk, i_rst_n, (in_acc && i_op == edt_pkg::OP_FETCH), (r_state == S_F_MUL1), "fetch did not enter scaling")
    `EDT_ASSERT_NEXT(a_frame_busy, i_clk, i_rst_n, (in_acc && i_op == edt_pkg::OP_LOAD && i_frame_end), (!o_ready && r_lpos == '0), "frame end did not start transform")
    `EDT_ASSERT_IMPL(a_env_bound, i_clk, i_rst_n, (r_state == S_R_CMP || r_state == S_B_CALC), (WW'(r_q) < w && WW'(r_u) < w), "envelope index left the row")

endmodule

FILE: test/euclidean_distance_transform_test.sv
module euclidean_distance_transform_test;
    import edt_pkg::*;

    // Clock, reset and block ports.
    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_wr_data;
    logic                   i_valid;
    logic                   o_ready;
    logic                   i_op;
    logic                   i_pixel_set;
    logic                   i_frame_end;
    logic                   o_valid;
    logic                   i_ready;
    logic [MM_W-1:0]        o_distance_mm;
    logic [SQ_W-1:0]        o_distance_squared;
    logic                   o_last_result;

    euclidean_distance_transform u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_op               (i_op),
        .i_pixel_set        (i_pixel_set),
        .i_frame_end        (i_frame_end),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_distance_mm      (o_distance_mm),
        .o_distance_squared (o_distance_squared),
        .o_last_result      (o_last_result)
    );

    // One expected fetch result.
    typedef struct {
        logic [MM_W-1:0] mm;
        logic [SQ_W-1:0] sq;
        logic            last;
    } distance_t;

    distance_t pending_distances[$];

    // Shadow of the block: registers, memories and positions.
    logic [CFG_DIM_W-1:0]   shadow_width;
    logic [CFG_DIM_W-1:0]   shadow_height;
    logic [CFG_SCALE_W-1:0] shadow_scale;
    logic [15:0]            col_dist[65536];
    logic [SQ_W-1:0]        sq_dist[65536];
    int                     env_src[256];
    int unsigned            env_st[256];
    int unsigned            load_pos;
    int unsigned            fetch_pos;

    int  error_count;
    int  items_sent;
    bit  quiet;        // no idling on either side
    bit  frame_ready;  // a transform ran with the current dimensions
    int  ready_hold;

    // Clock and timeout.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    initial begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int unsigned eff_width();
        if (shadow_width < 1) return 1;
        if (shadow_width > 256) return 256;
        return shadow_width;
    endfunction

    function automatic int unsigned eff_height();
        if (shadow_height < 1) return 1;
        if (shadow_height > 256) return 256;
        return shadow_height;
    endfunction

    // (x - i)^2 + g(i)^2 on the row starting at base.
    function automatic int unsigned parabola(int unsigned x, int unsigned i, int unsigned base);
        int unsigned dx;
        int unsigned gi;
        dx = (x > i) ? x - i : i - x;
        gi = col_dist[base + i];
        return dx * dx + gi * gi;
    endfunction

    // One plus the truncating separator of parabolas i < u, taken unsigned.
    function automatic int unsigned separator_next(int unsigned i, int unsigned u,
                                                   int unsigned base);
        longint gi, gu, num, den, s;
        int unsigned r;
        gi  = col_dist[base + i];
        gu  = col_dist[base + u];
        num = longint'(u) * u - longint'(i) * i + gu * gu - gi * gi;
        den = 2 * (longint'(u) - longint'(i));
        s   = num / den;
        r   = s[31:0];
        return r + 1;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Column pass, then lower envelope of parabolas per row.
    task automatic run_transform();
        int unsigned w, h, i, j, u, p, base, d2;
        logic [15:0] inf;
        int q;
        w   = eff_width();
        h   = eff_height();
        inf = w + h;
        for (i = 0; i < w; i++) begin
            if (col_dist[i] != 0) col_dist[i] = inf;
            for (j = 1; j < h; j++) begin
                p = j * w + i;
                if (col_dist[p] != 0) col_dist[p] = col_dist[p - w] + 16'd1;
            end
            for (j = h - 1; j > 0; j--) begin
                p = (j - 1) * w + i;
                if (col_dist[p + w] < col_dist[p]) col_dist[p] = col_dist[p + w] + 16'd1;
            end
        end
        for (j = 0; j < h; j++) begin
            base = j * w;
            q = 0;
            env_src[0] = 0;
            env_st[0]  = 0;
            for (u = 1; u < w; u++) begin
                while (q >= 0 && parabola(env_st[q], env_src[q], base) >
                                 parabola(env_st[q], u, base))
                    q--;
                if (q < 0) begin
                    q = 0;
                    env_src[0] = u;
                end else begin
                    p = separator_next(env_src[q], u, base);
                    if (p < w) begin
                        q++;
                        env_src[q] = u;
                        env_st[q]  = p;
                    end
                end
            end
            for (u = w; u > 0; u--) begin
                d2 = parabola(u - 1, env_src[q], base);
                sq_dist[base + u - 1] = (d2 > 32'hFFFFF) ? 20'hFFFFF : d2[SQ_W-1:0];
                if ((u - 1) == env_st[q] && q > 0) q--;
            end
        end
    endtask

    // Update the shadow for one accepted item; queue the result of a fetch.
    task automatic predict_item(logic op, logic set, logic fend);
        int unsigned n, p, k;
        logic [15:0] inf;
        longint unsigned r;
        distance_t e;
        n   = eff_width() * eff_height();
        inf = eff_width() + eff_height();
        if (op == OP_LOAD) begin
            p = load_pos;
            if (p < n) col_dist[p] = set ? 16'd0 : inf;
            if (fend) begin
                for (k = p + 1; k < n; k++) col_dist[k] = inf;
                run_transform();
                load_pos    = 0;
                fetch_pos   = 0;
                frame_ready = 1'b1;
            end else if (p < n) begin
                load_pos = p + 1;
            end
        end else begin
            p = fetch_pos;
            if (p >= n) p = 0;
            r = (int_sqrt(longint'(sq_dist[p]) * shadow_scale * shadow_scale) + 8) >> 4;
            if (r > 64'hFFFFFF) r = 64'hFFFFFF;
            e.mm   = r[MM_W-1:0];
            e.sq   = sq_dist[p];
            e.last = (p == n - 1);
            fetch_pos = e.last ? 0 : p + 1;
            pending_distances.push_back(e);
        end
    endtask

    // Send one item, maybe after a random gap, and hold it until accepted.
    task automatic send_item(logic op, logic set, logic fend);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_pixel_set <= set;
        i_frame_end <= fend;
        do @(posedge i_clk); while (!o_ready);
        predict_item(op, set, fend);
        items_sent++;
    endtask

    // Drain all results, then let any transform in flight finish.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_distances.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH: begin
                shadow_width = value[CFG_DIM_W-1:0];
                frame_ready  = 1'b0;
            end
            REG_IMAGE_HEIGHT: begin
                shadow_height = value[CFG_DIM_W-1:0];
                frame_ready   = 1'b0;
            end
            REG_MM_PER_PIXEL: shadow_scale = value;
            default: ;
        endcase
    endtask

    // Load one frame. Kind 0 is exact, 1 may end early, 2 runs past the end.
    // Density is the chance in 16 that a pixel is set.
    task automatic load_frame(int kind, int density);
        int unsigned n, count, k;
        n = eff_width() * eff_height();
        case (kind)
            1:       count = $urandom_range(1, n);
            2:       count = n + $urandom_range(1, 4);
            default: count = n;
        endcase
        for (k = 0; k < count; k++) begin
            // Slip in a fetch now and then; the stored results stay valid.
            if (frame_ready && $urandom_range(0, 15) == 0)
                send_item(OP_FETCH, $urandom_range(0, 1), $urandom_range(0, 1));
            send_item(OP_LOAD, $urandom_range(0, 15) < density, k == count - 1);
        end
    endtask

    task automatic fetch_results(int unsigned count);
        int unsigned k;
        for (k = 0; k < count; k++)
            send_item(OP_FETCH, $urandom_range(0, 1), $urandom_range(0, 1));
    endtask

    task automatic set_frame(int unsigned w, int unsigned h);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    // Small frames across the field values: all set, none set, lone pixels.
    task automatic test_basic_frames();
        write_reg(REG_MM_PER_PIXEL, 16'h1000);
        set_frame(3, 2);
        load_frame(0, 16);
        fetch_results(6);
        load_frame(0, 0);
        fetch_results(6);
        set_frame(1, 1);
        load_frame(0, 8);
        fetch_results(2);
    endtask

    // Widest row, tallest column and clamped dimension codes.
    task automatic test_extreme_sizes();
        set_frame(256, 2);
        load_frame(0, 1);
        fetch_results(512);
        set_frame(2, 256);
        load_frame(0, 1);
        fetch_results(512);
        set_frame(511, 1);
        load_frame(0, 2);
        fetch_results(256);
        set_frame(0, 0);
        load_frame(0, 8);
        fetch_results(2);
    endtask

    // Short and long frames, fetch wrap-around, zero and full scale.
    task automatic test_special_cases();
        set_frame(5, 4);
        load_frame(1, 4);
        fetch_results(25);
        load_frame(2, 4);
        fetch_results(20);
        write_reg(REG_MM_PER_PIXEL, 16'h0000);
        fetch_results(20);
        write_reg(REG_MM_PER_PIXEL, 16'hFFFF);
        fetch_results(20);
    endtask

    task automatic test_random_frames();
        int unsigned w, h, n;
        int pick;
        while (items_sent < 1700) begin
            pick = $urandom_range(0, 24);
            if (pick == 0) begin
                w = $urandom_range(256, 511);
                h = $urandom_range(1, 2);
            end else if (pick < 6) begin
                w = $urandom_range(1, 24);
                h = $urandom_range(1, 24);
            end else begin
                w = $urandom_range(1, 9);
                h = $urandom_range(1, 9);
            end
            set_frame(w, h);
            if ($urandom_range(0, 2) == 0) write_reg(REG_MM_PER_PIXEL, $urandom);
            n = eff_width() * eff_height();
            pick = $urandom_range(0, 9);
            load_frame(pick == 0 ? 1 : (pick == 1 ? 2 : 0), $urandom_range(0, 16));
            fetch_results(n + ($urandom_range(0, 3) == 0 ? $urandom_range(1, n) : 0));
        end
    endtask

    // Last part: no idling on either side.
    task automatic test_full_rate();
        quiet = 1'b1;
        set_frame(7, 5);
        write_reg(REG_MM_PER_PIXEL, $urandom);
        load_frame(0, 3);
        fetch_results(35);
        load_frame(0, 10);
        fetch_results(35);
    endtask

    // Receiver: random stall bursts, always ready in the quiet part.
    always @(posedge i_clk) begin
        if (quiet) begin
            i_ready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_ready    <= 1'b0;
            ready_hold <= $urandom_range(0, 12);
        end else begin
            i_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 20);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        distance_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_distances.size() == 0) begin
                $error("unexpected result: distance_squared %0d", o_distance_squared);
                error_count++;
            end else begin
                e = pending_distances.pop_front();
                if (o_distance_mm !== e.mm) begin
                    $error("distance_mm: expected %0d, got %0d", e.mm, o_distance_mm);
                    error_count++;
                end
                if (o_distance_squared !== e.sq) begin
                    $error("distance_squared: expected %0d, got %0d",
                           e.sq, o_distance_squared);
                    error_count++;
                end
                if (o_last_result !== e.last) begin
                    $error("last_result: expected %0d, got %0d", e.last, o_last_result);
                    error_count++;
                end
            end
        end
    end

    initial begin
        error_count   = 0;
        items_sent    = 0;
        quiet         = 1'b0;
        frame_ready   = 1'b0;
        ready_hold    = 0;
        shadow_width  = RST_IMAGE_WIDTH;
        shadow_height = RST_IMAGE_HEIGHT;
        shadow_scale  = RST_MM_PER_PIXEL;
        load_pos      = 0;
        fetch_pos     = 0;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= REG_IMAGE_WIDTH;
        i_cfg_wr_data <= '0;
        i_valid       <= 1'b0;
        i_op          <= OP_LOAD;
        i_pixel_set   <= 1'b0;
        i_frame_end   <= 1'b0;
        i_ready       <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_frames();
        test_extreme_sizes();
        test_special_cases();
        test_random_frames();
        test_full_rate();

        // Drop valid, drain, then allow for the block's latency.
        i_valid <= 1'b0;
        while (pending_distances.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
